[sv/x86a_pkg.sv]
// shared types, codes and helpers for the x86 add execute unit
`timescale 1ns / 1ps
`default_nettype none

package x86a_pkg;

    localparam int DATA_W   = 32;
    localparam int RF_DEPTH = 8;
    localparam int IDX_W    = 3;
    localparam int CMD_W    = 3;
    localparam int SIZE_W   = 2;

    // add forms
    localparam logic [CMD_W-1:0] CMD_RM_REG   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REG_RM   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ACC_IMM  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RM_IMM   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RM_SIMM8 = 3'd4;

    // operand sizes
    localparam logic [SIZE_W-1:0] SZ_BYTE  = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_WORD  = 2'd1;
    localparam logic [SIZE_W-1:0] SZ_DWORD = 2'd2;

    localparam logic [IDX_W-1:0] ACC_INDEX = 3'd0;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SIZE_W-1:0] operand_size;
        logic              memory_operand;
        logic [IDX_W-1:0]  rm_index;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] immediate;
        logic [DATA_W-1:0] memory_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum_value;
        logic              write_memory;
        logic              zero_flag;
        logic              parity_flag;
        logic              sign_flag;
        logic              carry_flag;
        logic              overflow_flag;
    } rsp_t;

    // register file write request
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    // the unused size code behaves as doubleword
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] res;
        unique case (sz)
            SZ_BYTE: res = SZ_BYTE;
            SZ_WORD: res = SZ_WORD;
            default: res = SZ_DWORD;
        endcase
        return res;
    endfunction

    // byte registers 4-7 live in bits 15:8 of entries 0-3
    function automatic logic [IDX_W-1:0] rf_addr(input logic [SIZE_W-1:0] sz,
                                                 input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (sz == SZ_BYTE)
        begin
            res = {1'b0, idx[IDX_W-2:0]};
        end
        else
        begin
            res = idx;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/x86a_stream_if.sv]
// valid/ready channel carrying one item of a chosen payload type
`timescale 1ns / 1ps
`default_nettype none

interface x86a_stream_if #(parameter type item_t = logic);

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[sv/x86_add_execute_unit.sv]
// x86 add execute unit: input stage, register file, alu and result register
//
//  channel | dir | payload | accepted when
//  --------+-----+---------+---------------------------
//  req     | in  | req_t   | req.valid && req.ready
//  rsp     | out | rsp_t   | rsp.valid && rsp.ready
//
// one item per cycle unless rsp stalls; results pass the stage and result registers
// the register file is read as an item enters the stage, and the item ahead
// writes at that same edge, so a bypass keeps back-to-back items exact
// reset clears the control flops and the eight register valid bits (file reads zero)
// the stage advances when the result register is free or being taken, or when it holds
// one of commands five to seven, which leaves without a result and touches no state
`timescale 1ns / 1ps
`default_nettype none

module x86_add_execute_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    x86a_stream_if.sink       req,
    x86a_stream_if.source     rsp
);
    import x86a_pkg::*;

    logic              stg_valid_reg;
    logic              stg_valid_next;
    req_t              stg_item_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_item_reg;

    logic              accept;
    logic              fire;
    logic              cmd_ok;
    rsp_t              result;
    rf_wr_t            wr_req;
    rf_wr_t            rf_wr;
    logic [SIZE_W-1:0] req_size;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic [DATA_W-1:0] word_a;
    logic [DATA_W-1:0] word_b;

    // port a serves the r/m register or the accumulator, port b the reg field
    assign req_size = eff_size(req.data.operand_size);
    assign raddr_a  = rf_addr(req_size, (req.data.command == CMD_ACC_IMM) ? ACC_INDEX
                                                                           : req.data.rm_index);
    assign raddr_b  = rf_addr(req_size, req.data.reg_index);

    assign fire      = stg_valid_reg && (!cmd_ok || !rsp_valid_reg || rsp.ready);
    assign req.ready = !stg_valid_reg || fire;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        rf_wr    = wr_req;
        rf_wr.en = fire && wr_req.en;
    end

    x86a_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .re      (accept),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .wr      (rf_wr),
        .rdata_a (word_a),
        .rdata_b (word_b)
    );

    x86a_alu u_alu (
        .item   (stg_item_reg),
        .word_a (word_a),
        .word_b (word_b),
        .cmd_ok (cmd_ok),
        .result (result),
        .wr_req (wr_req)
    );

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stg_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (fire && cmd_ok)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_item_reg <= req.data;
        end
        if (fire && cmd_ok)
        begin
            rsp_item_reg <= result;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_item_reg;

    // a stalled stage keeps its item and its read data context
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && !fire) |=> (stg_valid_reg && $stable(stg_item_reg)))
        else $error("stage item changed while stalled");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rsp_valid_reg && !rsp.ready) |-> !cmd_ok)
        else $error("result overwritten before it was taken");

    // a memory destination never updates the register file
    a_mem_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.write_memory) |-> !rf_wr.en)
        else $error("register file written for a memory destination");

    // a result appears only after an item left the stage
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(fire && cmd_ok))
        else $error("result raised without an executed item");

endmodule

`default_nettype wire

[sv/x86a_ram.sv]
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module x86a_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

[sv/x86a_regfile.sv]
// eight-entry register file: ram, reset valid bits and write bypass
`timescale 1ns / 1ps
`default_nettype none

module x86a_regfile (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            re,
    input  wire logic [x86a_pkg::IDX_W-1:0]      raddr_a,
    input  wire logic [x86a_pkg::IDX_W-1:0]      raddr_b,
    input  wire x86a_pkg::rf_wr_t                wr,
    output logic      [x86a_pkg::DATA_W-1:0]     rdata_a,
    output logic      [x86a_pkg::DATA_W-1:0]     rdata_b
);
    import x86a_pkg::*;

    logic [RF_DEPTH-1:0] valid_reg;
    logic                hit_a_reg;
    logic                hit_b_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;
    logic [DATA_W-1:0]   byp_data_reg;
    logic [DATA_W-1:0]   ram_a;
    logic [DATA_W-1:0]   ram_b;

    x86a_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RF_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (wr.en),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (re)
            begin
                hit_a_reg <= wr.en && (wr.addr == raddr_a);
                hit_b_reg <= wr.en && (wr.addr == raddr_b);
                vld_a_reg <= valid_reg[raddr_a];
                vld_b_reg <= valid_reg[raddr_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            byp_data_reg <= wr.data;
        end
    end

    // a write landing with the read wins, an unwritten entry reads zero
    assign rdata_a = hit_a_reg ? byp_data_reg : (vld_a_reg ? ram_a : '0);
    assign rdata_b = hit_b_reg ? byp_data_reg : (vld_b_reg ? ram_b : '0);

endmodule

`default_nettype wire

[sv/x86a_alu.sv]
// operand selection, add, flags and destination merge for one item
`timescale 1ns / 1ps
`default_nettype none

module x86a_alu (
    input  wire x86a_pkg::req_t              item,
    input  wire logic [x86a_pkg::DATA_W-1:0] word_a,
    input  wire logic [x86a_pkg::DATA_W-1:0] word_b,
    output logic                             cmd_ok,
    output x86a_pkg::rsp_t                   result,
    output x86a_pkg::rf_wr_t                 wr_req
);
    import x86a_pkg::*;

    function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] sz);
        logic [DATA_W-1:0] res;
        unique case (sz)
            SZ_BYTE: res = 32'h0000_00FF;
            SZ_WORD: res = 32'h0000_FFFF;
            default: res = 32'hFFFF_FFFF;
        endcase
        return res;
    endfunction

    // register operand at the given size, zero-extended
    function automatic logic [DATA_W-1:0] pick(input logic [DATA_W-1:0] w,
                                               input logic [SIZE_W-1:0] sz,
                                               input logic [IDX_W-1:0]  idx);
        logic [DATA_W-1:0] res;
        unique case (sz)
            SZ_BYTE: res = idx[IDX_W-1] ? {24'd0, w[15:8]} : {24'd0, w[7:0]};
            SZ_WORD: res = {16'd0, w[15:0]};
            default: res = w;
        endcase
        return res;
    endfunction

    logic [SIZE_W-1:0] sz;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] topbit;
    logic [DATA_W-1:0] rm_val;
    logic [DATA_W-1:0] rg_val;
    logic [DATA_W-1:0] acc_val;
    logic [DATA_W-1:0] imm_val;
    logic [DATA_W-1:0] simm_val;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [DATA_W-1:0] old_word;
    logic [DATA_W-1:0] merged;
    logic [IDX_W-1:0]  dst;
    logic              to_mem;
    logic [DATA_W:0]   full;
    logic [DATA_W-1:0] sum;
    logic              carry;

    always_comb
    begin
        sz       = eff_size(item.operand_size);
        mask     = size_mask(sz);
        topbit   = mask ^ (mask >> 1);
        rm_val   = item.memory_operand ? (item.memory_data & mask)
                                       : pick(word_a, sz, item.rm_index);
        rg_val   = pick(word_b, sz, item.reg_index);
        acc_val  = pick(word_a, sz, ACC_INDEX);
        imm_val  = item.immediate & mask;
        simm_val = {{24{item.immediate[7]}}, item.immediate[7:0]} & mask;

        cmd_ok   = 1'b1;
        op_a     = rm_val;
        op_b     = rg_val;
        to_mem   = item.memory_operand;
        dst      = item.rm_index;
        old_word = word_a;

        unique case (item.command)
            CMD_RM_REG:
            begin
                op_b = rg_val;
            end
            CMD_REG_RM:
            begin
                op_a     = rg_val;
                op_b     = rm_val;
                to_mem   = 1'b0;
                dst      = item.reg_index;
                old_word = word_b;
            end
            CMD_ACC_IMM:
            begin
                op_a   = acc_val;
                op_b   = imm_val;
                to_mem = 1'b0;
                dst    = ACC_INDEX;
            end
            CMD_RM_IMM:
            begin
                op_b = imm_val;
            end
            CMD_RM_SIMM8:
            begin
                op_b = simm_val;
            end
            default:
            begin
                cmd_ok = 1'b0;
                to_mem = 1'b0;
            end
        endcase

        full = {1'b0, op_a} + {1'b0, op_b};
        sum  = full[DATA_W-1:0] & mask;

        unique case (sz)
            SZ_BYTE:
            begin
                carry  = full[8];
                merged = dst[IDX_W-1] ? {old_word[31:16], sum[7:0], old_word[7:0]}
                                      : {old_word[31:8], sum[7:0]};
            end
            SZ_WORD:
            begin
                carry  = full[16];
                merged = {old_word[31:16], sum[15:0]};
            end
            default:
            begin
                carry  = full[DATA_W];
                merged = sum;
            end
        endcase

        result.sum_value     = sum;
        result.write_memory  = to_mem;
        result.zero_flag     = (sum == '0);
        result.parity_flag   = ~^sum[7:0];
        result.sign_flag     = |(sum & topbit);
        result.carry_flag    = carry;
        result.overflow_flag = |((op_a ^ sum) & (op_b ^ sum) & topbit);

        wr_req.en   = cmd_ok && !to_mem;
        wr_req.addr = rf_addr(sz, dst);
        wr_req.data = merged;
    end

endmodule

`default_nettype wire

[tb/x86_add_execute_unit_test.sv]
// self-checking testbench for the x86 add execute unit: directed table, then random adds
`timescale 1ns / 1ps

module x86_add_execute_unit_test;

    import x86a_pkg::*;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_RSVD7 = 3'd7;
    localparam logic [SIZE_W-1:0] SZ_RSVD   = 2'd3;

    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 800000;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } row_t;

    logic clk;
    logic rst_n;

    x86a_stream_if #(.item_t(req_t)) req_ch ();
    x86a_stream_if #(.item_t(rsp_t)) rsp_ch ();

    x86_add_execute_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [DATA_W-1:0] arch_regs [RF_DEPTH];
    rsp_t              pending_sums [$];
    row_t              directed [$];
    rsp_t              head_sum;
    int                errors;
    int                accepted_count;
    int                silent_count;
    int                checked_count;
    int                burst_left;
    int                cycles;
    bit                held_off;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [DATA_W-1:0] reg_value(input logic [SIZE_W-1:0] sz,
                                                   input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] v;
        case (sz)
            SZ_BYTE: v = {24'b0, idx[2] ? arch_regs[idx[1:0]][15:8] : arch_regs[idx[1:0]][7:0]};
            SZ_WORD: v = {16'b0, arch_regs[idx][15:0]};
            default: v = arch_regs[idx];
        endcase
        return v;
    endfunction

    // one add against the shadow register file
    task automatic model_add(input req_t it, output bit produced, output rsp_t res);
        logic [SIZE_W-1:0] sz;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] rm_val;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        logic [DATA_W:0]   full;
        logic [IDX_W-1:0]  dst;
        bit                to_mem;
        produced = 1'b0;
        res = '0;
        if (it.command <= CMD_RM_SIMM8)
        begin
            case (it.operand_size)
                SZ_BYTE: sz = SZ_BYTE;
                SZ_WORD: sz = SZ_WORD;
                default: sz = SZ_DWORD;
            endcase
            mask = (sz == SZ_BYTE) ? 32'h0000_00FF : (sz == SZ_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
            top  = (sz == SZ_BYTE) ? 32'h0000_0080 : (sz == SZ_WORD) ? 32'h0000_8000 : 32'h8000_0000;
            rm_val = it.memory_operand ? (it.memory_data & mask) : reg_value(sz, it.rm_index);
            to_mem = 1'b0;
            dst = it.rm_index;
            case (it.command)
                CMD_RM_REG:
                begin
                    a = rm_val;
                    b = reg_value(sz, it.reg_index);
                    to_mem = it.memory_operand;
                end
                CMD_REG_RM:
                begin
                    a = reg_value(sz, it.reg_index);
                    b = rm_val;
                    dst = it.reg_index;
                end
                CMD_ACC_IMM:
                begin
                    a = reg_value(sz, ACC_INDEX);
                    b = it.immediate & mask;
                    dst = ACC_INDEX;
                end
                CMD_RM_IMM:
                begin
                    a = rm_val;
                    b = it.immediate & mask;
                    to_mem = it.memory_operand;
                end
                default:
                begin
                    a = rm_val;
                    b = {{24{it.immediate[7]}}, it.immediate[7:0]} & mask;
                    to_mem = it.memory_operand;
                end
            endcase
            full = {1'b0, a} + {1'b0, b};
            r = full[DATA_W-1:0] & mask;
            if (!to_mem)
            begin
                case (sz)
                    SZ_BYTE:
                    begin
                        if (dst[2])
                            arch_regs[dst[1:0]][15:8] = r[7:0];
                        else
                            arch_regs[dst[1:0]][7:0] = r[7:0];
                    end
                    SZ_WORD: arch_regs[dst][15:0] = r[15:0];
                    default: arch_regs[dst] = r;
                endcase
            end
            res.sum_value     = r;
            res.write_memory  = to_mem;
            res.zero_flag     = (r == '0);
            res.parity_flag   = ~^r[7:0];
            res.sign_flag     = |(r & top);
            res.carry_flag    = (full > {1'b0, mask});
            res.overflow_flag = |((a ^ r) & (b ^ r) & top);
            produced = 1'b1;
        end
    endtask

    // corners show up often so carries and overflows hit every size
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 15))
            0: v = 32'h0000_0000;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = {16'($urandom_range(0, 65535)), 16'h7F80} | 32'h0000_007F;
            5: v = {16'hFFFF, 16'h8000} ^ {16'($urandom_range(0, 65535)), 16'h0000};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic req_t random_add();
        req_t it;
        if ($urandom_range(0, 24) == 0)
            it.command = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        else
            it.command = CMD_W'($urandom_range(CMD_RM_REG, CMD_RM_SIMM8));
        if ($urandom_range(0, 15) == 0)
            it.operand_size = SZ_RSVD;
        else
            it.operand_size = SIZE_W'($urandom_range(SZ_BYTE, SZ_DWORD));
        it.memory_operand = 1'($urandom_range(0, 1));
        it.rm_index       = IDX_W'($urandom_range(0, RF_DEPTH - 1));
        it.reg_index      = IDX_W'($urandom_range(0, RF_DEPTH - 1));
        it.immediate      = pick_operand();
        it.memory_data    = pick_operand();
        return it;
    endfunction

    task automatic add_row(input req_t it, input bit typed, input rsp_t want);
        row_t rw;
        rw.item  = it;
        rw.typed = typed;
        rw.want  = want;
        directed.push_back(rw);
    endtask

    task automatic send_item(input req_t it, input bit typed, input rsp_t want);
        bit   produced;
        rsp_t predicted;
        int   gap;
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        model_add(it, produced, predicted);
        accepted_count++;
        if (produced)
            pending_sums.push_back(typed ? want : predicted);
        else
            silent_count++;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            burst_left = $urandom_range(30, 100);
            gap = 0;
        end
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:49]:  gap = 0;
                [50:84]: gap = $urandom_range(1, 3);
                [85:96]: gap = $urandom_range(4, 10);
                default: gap = $urandom_range(20, 60);
            endcase
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: random stalls plus one long hold-off to back the block up
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && accepted_count >= HOLD_AT)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) < 8)
                repeat ($urandom_range(1, 24)) @(posedge clk);
            else
                repeat ($urandom_range(50, 300)) @(posedge clk);
            case ($urandom_range(0, 99)) inside
                [0:54]:  stall = 0;
                [55:89]: stall = $urandom_range(1, 3);
                [90:97]: stall = $urandom_range(4, 12);
                default: stall = $urandom_range(20, 60);
            endcase
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected result: sum_value %h", rsp_ch.data.sum_value);
                errors++;
            end
            else
            begin
                head_sum = pending_sums.pop_front();
                checked_count++;
                if (rsp_ch.data.sum_value !== head_sum.sum_value)
                begin
                    $error("sum_value: expected %h, got %h",
                           head_sum.sum_value, rsp_ch.data.sum_value);
                    errors++;
                end
                if (rsp_ch.data.write_memory !== head_sum.write_memory)
                begin
                    $error("write_memory: expected %b, got %b",
                           head_sum.write_memory, rsp_ch.data.write_memory);
                    errors++;
                end
                if (rsp_ch.data.zero_flag !== head_sum.zero_flag)
                begin
                    $error("zero_flag: expected %b, got %b",
                           head_sum.zero_flag, rsp_ch.data.zero_flag);
                    errors++;
                end
                if (rsp_ch.data.parity_flag !== head_sum.parity_flag)
                begin
                    $error("parity_flag: expected %b, got %b",
                           head_sum.parity_flag, rsp_ch.data.parity_flag);
                    errors++;
                end
                if (rsp_ch.data.sign_flag !== head_sum.sign_flag)
                begin
                    $error("sign_flag: expected %b, got %b",
                           head_sum.sign_flag, rsp_ch.data.sign_flag);
                    errors++;
                end
                if (rsp_ch.data.carry_flag !== head_sum.carry_flag)
                begin
                    $error("carry_flag: expected %b, got %b",
                           head_sum.carry_flag, rsp_ch.data.carry_flag);
                    errors++;
                end
                if (rsp_ch.data.overflow_flag !== head_sum.overflow_flag)
                begin
                    $error("overflow_flag: expected %b, got %b",
                           head_sum.overflow_flag, rsp_ch.data.overflow_flag);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_sums.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        errors = 0;
        accepted_count = 0;
        silent_count = 0;
        checked_count = 0;
        burst_left = 0;
        foreach (arch_regs[k])
            arch_regs[k] = '0;

        // rsp_t order: sum, write_memory, zf, pf, sf, cf, of
        add_row(req_t'{CMD_ACC_IMM, SZ_BYTE, 1'b0, 3'd0, 3'd0, 32'h0000_0000, 32'h0}, 1'b1,
                rsp_t'{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
        add_row(req_t'{CMD_ACC_IMM, SZ_BYTE, 1'b0, 3'd0, 3'd0, 32'h0000_00FF, 32'h0}, 1'b1,
                rsp_t'{32'h0000_00FF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0});
        add_row(req_t'{CMD_ACC_IMM, SZ_BYTE, 1'b0, 3'd0, 3'd0, 32'h0000_0001, 32'h0}, 1'b1,
                rsp_t'{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0});
        add_row(req_t'{CMD_ACC_IMM, SZ_DWORD, 1'b0, 3'd0, 3'd0, 32'h7FFF_FFFF, 32'h0}, 1'b1,
                rsp_t'{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
        add_row(req_t'{CMD_ACC_IMM, SZ_DWORD, 1'b0, 3'd0, 3'd0, 32'h0000_0001, 32'h0}, 1'b1,
                rsp_t'{32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1});
        add_row(req_t'{CMD_ACC_IMM, SZ_DWORD, 1'b0, 3'd0, 3'd0, 32'h8000_0000, 32'h0}, 1'b1,
                rsp_t'{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1});
        // unused commands leave no result behind
        add_row(req_t'{CMD_RSVD5, SZ_DWORD, 1'b0, 3'd0, 3'd0, 32'hFFFF_FFFF, 32'h1}, 1'b0, '0);
        add_row(req_t'{CMD_RSVD7, SZ_RSVD, 1'b1, 3'd7, 3'd7, 32'h1234_5678, 32'h1}, 1'b0, '0);
        add_row(req_t'{CMD_ACC_IMM, SZ_WORD, 1'b0, 3'd0, 3'd0, 32'h1234_FFFF, 32'h0}, 1'b1,
                rsp_t'{32'h0000_FFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0});
        // memory destinations
        add_row(req_t'{CMD_RM_IMM, SZ_BYTE, 1'b1, 3'd5, 3'd0, 32'hABCD_EF80, 32'h1234_5680}, 1'b1,
                rsp_t'{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1});
        add_row(req_t'{CMD_RM_SIMM8, SZ_DWORD, 1'b1, 3'd2, 3'd0, 32'h1234_56FF, 32'h1}, 1'b1,
                rsp_t'{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0});
        add_row(req_t'{CMD_RM_SIMM8, SZ_BYTE, 1'b1, 3'd6, 3'd1, 32'h0000_0080, 32'h80}, 1'b1,
                rsp_t'{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1});
        add_row(req_t'{CMD_RM_SIMM8, SZ_WORD, 1'b1, 3'd3, 3'd4, 32'hFFFF_FF7F, 32'h7F81}, 1'b1,
                rsp_t'{32'h0000_8000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1});
        add_row(req_t'{CMD_RM_IMM, SZ_RSVD, 1'b1, 3'd1, 3'd2, 32'h0000_0001, 32'hFFFF_FFFF}, 1'b1,
                rsp_t'{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0});
        // register forms and memory operands, high and low byte aliasing
        add_row(req_t'{CMD_ACC_IMM, SZ_BYTE, 1'b0, 3'd0, 3'd0, 32'h0000_005A, 32'h0}, 1'b0, '0);
        add_row(req_t'{CMD_RM_REG, SZ_BYTE, 1'b0, 3'd4, 3'd0, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0);
        add_row(req_t'{CMD_REG_RM, SZ_BYTE, 1'b0, 3'd4, 3'd7, 32'h0, 32'h0}, 1'b0, '0);
        add_row(req_t'{CMD_REG_RM, SZ_WORD, 1'b1, 3'd0, 3'd3, 32'h0, 32'hFFFF_1234}, 1'b0, '0);
        add_row(req_t'{CMD_RM_REG, SZ_DWORD, 1'b1, 3'd5, 3'd0, 32'h0, 32'h8000_0001}, 1'b0, '0);
        add_row(req_t'{CMD_RM_IMM, SZ_DWORD, 1'b0, 3'd6, 3'd0, 32'hDEAD_BEEF, 32'h0}, 1'b0, '0);
        add_row(req_t'{CMD_RM_SIMM8, SZ_WORD, 1'b0, 3'd6, 3'd0, 32'h0000_0080, 32'h0}, 1'b0, '0);
        add_row(req_t'{CMD_ACC_IMM, SZ_WORD, 1'b1, 3'd5, 3'd6, 32'h0000_1234, 32'h5555}, 1'b0, '0);
        add_row(req_t'{CMD_RM_REG, SZ_DWORD, 1'b0, 3'd6, 3'd6, 32'h0, 32'h0}, 1'b0, '0);
        add_row(req_t'{CMD_RSVD6, SZ_BYTE, 1'b0, 3'd1, 3'd1, 32'h0, 32'h0}, 1'b0, '0);
        add_row(req_t'{CMD_REG_RM, SZ_DWORD, 1'b0, 3'd6, 3'd7, 32'h0, 32'h0}, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[n])
            send_item(directed[n].item, directed[n].typed, directed[n].want);
        repeat (RANDOM_ITEMS)
            send_item(random_add(), 1'b0, '0);
        req_ch.valid <= 1'b0;

        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent (%0d from the table), %0d results checked, %0d items with no result",
                 accepted_count, directed.size(), checked_count, silent_count);
        $display("forms 0-4 at byte, word and doubleword, register and memory operands, long output hold-off");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[x86_add_execute_unit.f]
sv/x86a_pkg.sv
sv/x86a_stream_if.sv
sv/x86a_ram.sv
sv/x86a_regfile.sv
sv/x86a_alu.sv
sv/x86_add_execute_unit.sv
tb/x86_add_execute_unit_test.sv
